FILE: rtl/core/dwpa_pkg.sv
// dwpa_pkg: shared widths, reset constants and the result record type
// used by the dual wheel period averager; no dependencies
`default_nettype none

package dwpa_pkg;

  localparam int StampW        = 16;
  localparam int PeriodW       = 17;
  localparam int SumW          = 22;
  localparam int DefStoreDepth = 20;
  localparam int FifoDepth     = 8;
  localparam int FifoAw        = $clog2(FifoDepth);
  localparam int CountW        = $clog2(FifoDepth + 1);

  localparam logic [StampW-1:0] TopReset = 16'd60000;

  typedef struct packed {
    logic               wheel_out;
    logic               period_done;
    logic [PeriodW-1:0] new_period;
    logic [PeriodW-1:0] average_period;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/dwpa_in_if.sv
// dwpa_in_if: valid/ready channel carrying one capture event
// depends on dwpa_pkg
`default_nettype none

interface dwpa_in_if;
  logic                       valid;
  logic                       ready;
  logic                       wheel;
  logic [dwpa_pkg::StampW-1:0] timestamp;

  modport source (output valid, wheel, timestamp, input ready);
  modport sink   (input valid, wheel, timestamp, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dwpa_out_if.sv
// dwpa_out_if: valid/ready channel carrying one averaged period result
// depends on dwpa_pkg
`default_nettype none

interface dwpa_out_if;
  logic                         valid;
  logic                         ready;
  logic                         wheel_out;
  logic                         period_done;
  logic [dwpa_pkg::PeriodW-1:0] new_period;
  logic [dwpa_pkg::PeriodW-1:0] average_period;

  modport source (output valid, wheel_out, period_done, new_period, average_period,
                  input ready);
  modport sink   (input valid, wheel_out, period_done, new_period, average_period,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dwpa_store.sv
// dwpa_store: per-wheel ring memory of recent periods, registered read,
// entry valid bits cleared at reset, write-to-read forwarding; uses dwpa_pkg
`default_nettype none

module dwpa_store #(
  parameter int STORE_DEPTH = dwpa_pkg::DefStoreDepth,
  parameter int SlotW       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         rd_wheel,
  input  wire logic [SlotW-1:0]             rd_slot,
  output      logic [dwpa_pkg::PeriodW-1:0] rd_data,
  input  wire logic                         wr_en,
  input  wire logic                         wr_wheel,
  input  wire logic [SlotW-1:0]             wr_slot,
  input  wire logic [dwpa_pkg::PeriodW-1:0] wr_data
);

  logic [dwpa_pkg::PeriodW-1:0] mem [2][STORE_DEPTH];
  logic [STORE_DEPTH-1:0]       entry_valid [2];

  logic [dwpa_pkg::PeriodW-1:0] q;
  logic                         q_valid;
  logic                         hit;
  logic [dwpa_pkg::PeriodW-1:0] fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_wheel][wr_slot] <= wr_data;
    end
    q   <= mem[rd_wheel][rd_slot];
    fwd <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid[0] <= '0;
      entry_valid[1] <= '0;
      q_valid        <= 1'b0;
      hit            <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_wheel][wr_slot] <= 1'b1;
      end
      q_valid <= entry_valid[rd_wheel][rd_slot];
      hit     <= wr_en && (wr_wheel == rd_wheel) && (wr_slot == rd_slot);
    end
  end

  // same-edge write wins over the stale array read
  always_comb begin
    if (hit) begin
      rd_data = fwd;
    end else if (q_valid) begin
      rd_data = q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dwpa_div.sv
// dwpa_div: registered reciprocal multiply giving sum / STORE_DEPTH, truncated
// exact for every sum whose quotient fits in PeriodW bits; uses dwpa_pkg
`default_nettype none

module dwpa_div #(
  parameter int STORE_DEPTH = dwpa_pkg::DefStoreDepth
) (
  input  wire logic                         clk,
  input  wire logic [dwpa_pkg::SumW-1:0]    sum_in,
  output      logic [dwpa_pkg::PeriodW-1:0] quot
);

  localparam int ShiftK = dwpa_pkg::SumW + $clog2(STORE_DEPTH);
  localparam longint unsigned Recip =
    ((64'd1 << ShiftK) + STORE_DEPTH - 1) / STORE_DEPTH;
  localparam int RecipW = dwpa_pkg::SumW + 1;
  localparam int ProdW  = dwpa_pkg::SumW + RecipW;

  localparam logic [RecipW-1:0] RecipM = RecipW'(Recip);

  logic [ProdW-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= ProdW'(sum_in) * ProdW'(RecipM);
  end

  assign quot = prod[ShiftK +: dwpa_pkg::PeriodW];

endmodule

`default_nettype wire

FILE: rtl/core/dwpa_fifo.sv
// dwpa_fifo: small result queue in front of the output channel
// uses dwpa_pkg for depth and the result record
`default_nettype none

module dwpa_fifo (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire dwpa_pkg::result_t           push_data,
  input  wire logic                        pop,
  output      dwpa_pkg::result_t           head,
  output      logic [dwpa_pkg::CountW-1:0] count
);

  dwpa_pkg::result_t               mem [dwpa_pkg::FifoDepth];
  logic [dwpa_pkg::FifoAw-1:0]     wr_ptr;
  logic [dwpa_pkg::FifoAw-1:0]     rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head = mem[rd_ptr];

endmodule

`default_nettype wire

FILE: rtl/core/dual_wheel_period_averager.sv
// dual_wheel_period_averager: capture pairs to periods, per-wheel moving average
// depends on dwpa_pkg, dwpa_in_if, dwpa_out_if, dwpa_store, dwpa_div, dwpa_fifo
//
//  channel  | role   | payload                                              | handshake
//  in_ch    | sink   | wheel, timestamp                                     | valid/ready
//  out_ch   | source | wheel_out, period_done, new_period, average_period   | valid/ready
//  cfg      | write  | cfg_wr_data (counter_top)                            | cfg_wr_en
//
// one event per cycle while in_ch.ready is high; a result is registered through the store read,
// the sum update and the divider before it enters the output queue, and can leave on the following edge
// the period store is read one cycle and written back the next, with forwarding
// reset clears entry valid bits at once, so no clearing pass is needed
// the input takes events while fewer than 8 results are in flight or queued
`default_nettype none

module dual_wheel_period_averager #(
  parameter int STORE_DEPTH = dwpa_pkg::DefStoreDepth
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [dwpa_pkg::StampW-1:0] cfg_wr_data,
  dwpa_in_if.sink                          in_ch,
  dwpa_out_if.source                       out_ch
);

  localparam int SlotW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int StampW = dwpa_pkg::StampW;
  localparam int PerW   = dwpa_pkg::PeriodW;
  localparam int SumW   = dwpa_pkg::SumW;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(STORE_DEPTH - 1);

  logic [StampW-1:0] counter_top;

  logic              awaiting   [2];
  logic [StampW-1:0] first_stamp[2];
  logic [SlotW-1:0]  slot       [2];
  logic [SumW-1:0]   sum        [2];

  logic              accept;
  logic              w0;
  logic [StampW-1:0] ts0;
  logic [StampW-1:0] first0;
  logic [SlotW-1:0]  slot0;
  logic [PerW-1:0]   up0;
  logic [PerW-1:0]   period0;

  logic              v1, w1, done1;
  logic [PerW-1:0]   period1;
  logic [SlotW-1:0]  slot1;
  logic [PerW-1:0]   old1;
  logic [SumW-1:0]   sum_upd;

  logic              v2, w2, done2;
  logic [PerW-1:0]   period2;
  logic [SumW-1:0]   sum2;

  logic              v3, w3, done3;
  logic [PerW-1:0]   period3;
  logic [PerW-1:0]   quot3;

  dwpa_pkg::result_t             push_data;
  dwpa_pkg::result_t             head;
  logic [dwpa_pkg::CountW-1:0]   fifo_count;
  logic [dwpa_pkg::CountW:0]     occupancy;
  logic                          pop;

  assign occupancy = (dwpa_pkg::CountW + 1)'(fifo_count)
                   + (dwpa_pkg::CountW + 1)'(v1)
                   + (dwpa_pkg::CountW + 1)'(v2)
                   + (dwpa_pkg::CountW + 1)'(v3);
  assign in_ch.ready = occupancy < (dwpa_pkg::CountW + 1)'(dwpa_pkg::FifoDepth);
  assign accept      = in_ch.valid && in_ch.ready;

  assign w0     = in_ch.wheel;
  assign ts0    = in_ch.timestamp;
  assign first0 = first_stamp[w0];
  assign slot0  = slot[w0];

  // wrap through the counter top, clamped at zero
  assign up0 = PerW'(counter_top) + PerW'(ts0) + PerW'(1);
  always_comb begin
    if (ts0 > first0) begin
      period0 = PerW'(ts0 - first0);
    end else if (up0 < PerW'(first0)) begin
      period0 = '0;
    end else begin
      period0 = up0 - PerW'(first0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_top <= dwpa_pkg::TopReset;
    end else if (cfg_wr_en) begin
      counter_top <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting[0]    <= 1'b0;
      awaiting[1]    <= 1'b0;
      first_stamp[0] <= '0;
      first_stamp[1] <= '0;
      slot[0]        <= '0;
      slot[1]        <= '0;
    end else if (accept) begin
      if (!awaiting[w0]) begin
        first_stamp[w0] <= ts0;
        awaiting[w0]    <= 1'b1;
      end else begin
        awaiting[w0] <= 1'b0;
        slot[w0]     <= (slot0 == LastSlot) ? '0 : slot0 + 1'b1;
      end
    end
  end

  dwpa_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .SlotW       (SlotW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_wheel (w0),
    .rd_slot  (slot0),
    .rd_data  (old1),
    .wr_en    (v1 && done1),
    .wr_wheel (w1),
    .wr_slot  (slot1),
    .wr_data  (period1)
  );

  // stage 1: read-modify-write of the ring entry and running sum
  always_ff @(posedge clk) begin
    w1      <= w0;
    done1   <= awaiting[w0];
    period1 <= awaiting[w0] ? period0 : '0;
    slot1   <= slot0;
  end

  assign sum_upd = sum[w1] - SumW'(old1) + SumW'(period1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum[0] <= '0;
      sum[1] <= '0;
    end else if (v1 && done1) begin
      sum[w1] <= sum_upd;
    end
  end

  always_ff @(posedge clk) begin
    w2      <= w1;
    done2   <= done1;
    period2 <= period1;
    sum2    <= done1 ? sum_upd : sum[w1];
  end

  dwpa_div #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_div (
    .clk    (clk),
    .sum_in (sum2),
    .quot   (quot3)
  );

  always_ff @(posedge clk) begin
    w3      <= w2;
    done3   <= done2;
    period3 <= period2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign push_data.wheel_out      = w3;
  assign push_data.period_done    = done3;
  assign push_data.new_period     = period3;
  assign push_data.average_period = quot3;

  assign pop = out_ch.valid && out_ch.ready;

  dwpa_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (v3),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .count     (fifo_count)
  );

  assign out_ch.valid          = fifo_count != '0;
  assign out_ch.wheel_out      = head.wheel_out;
  assign out_ch.period_done    = head.period_done;
  assign out_ch.new_period     = head.new_period;
  assign out_ch.average_period = head.average_period;

endmodule

`default_nettype wire

FILE: tb/dwpa_tb_pkg.sv
// dwpa_tb_pkg: result scoreboard for the dual wheel period averager bench
// predicts each capture's result from its own per-wheel ring of periods
// depends on dwpa_pkg
package dwpa_tb_pkg;

  import dwpa_pkg::*;

  class period_scoreboard;
    logic [StampW-1:0]  top;
    bit                 armed [2];
    logic [StampW-1:0]  start_stamp [2];
    logic [PeriodW-1:0] ring [2][DefStoreDepth];
    int unsigned        ring_slot [2];
    logic [SumW-1:0]    ring_sum [2];
    result_t            awaited_q [$];
    int                 errors;

    function new();
      top    = TopReset;
      errors = 0;
      for (int w = 0; w < 2; w++) begin
        armed[w]       = 1'b0;
        start_stamp[w] = '0;
        ring_slot[w]   = 0;
        ring_sum[w]    = '0;
        for (int i = 0; i < DefStoreDepth; i++) ring[w][i] = '0;
      end
    endfunction

    function void set_top(logic [StampW-1:0] value);
      top = value;
    endfunction

    // period between two stamps, wrapping through the counter top
    function logic [PeriodW-1:0] wheel_period(logic [StampW-1:0] first,
                                              logic [StampW-1:0] second);
      logic [PeriodW-1:0] up;
      if (second > first) return PeriodW'(second - first);
      up = PeriodW'(top) + PeriodW'(second) + PeriodW'(1);
      if (up < PeriodW'(first)) return '0;
      return up - PeriodW'(first);
    endfunction

    function void note_capture(logic wheel, logic [StampW-1:0] stamp);
      result_t     res;
      int unsigned s;
      res.wheel_out   = wheel;
      res.period_done = 1'b0;
      res.new_period  = '0;
      if (!armed[wheel]) begin
        start_stamp[wheel] = stamp;
        armed[wheel]       = 1'b1;
      end else begin
        s = ring_slot[wheel];
        res.new_period     = wheel_period(start_stamp[wheel], stamp);
        res.period_done    = 1'b1;
        ring_sum[wheel]    = ring_sum[wheel] - SumW'(ring[wheel][s])
                             + SumW'(res.new_period);
        ring[wheel][s]     = res.new_period;
        ring_slot[wheel]   = (s + 1 >= DefStoreDepth) ? 0 : s + 1;
        armed[wheel]       = 1'b0;
      end
      res.average_period = PeriodW'(ring_sum[wheel] / DefStoreDepth);
      awaited_q.push_back(res);
    endfunction

    function void check_result(logic wheel_out, logic period_done,
                               logic [PeriodW-1:0] new_period,
                               logic [PeriodW-1:0] average_period);
      result_t exp;
      if (awaited_q.size() == 0) begin
        $error("unexpected result: wheel_out %0d period_done %0d", wheel_out, period_done);
        errors++;
        return;
      end
      exp = awaited_q.pop_front();
      if (wheel_out !== exp.wheel_out) begin
        $error("wheel_out: expected %0d, got %0d", exp.wheel_out, wheel_out);
        errors++;
      end
      if (period_done !== exp.period_done) begin
        $error("period_done: expected %0d, got %0d", exp.period_done, period_done);
        errors++;
      end
      if (new_period !== exp.new_period) begin
        $error("new_period: expected %0d, got %0d", exp.new_period, new_period);
        errors++;
      end
      if (average_period !== exp.average_period) begin
        $error("average_period: expected %0d, got %0d", exp.average_period, average_period);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
// tb_top: random and directed capture traffic for dual_wheel_period_averager
// with random stalls on both channels and two long output hold-offs
// depends on dwpa_pkg, dwpa_in_if, dwpa_out_if, dwpa_tb_pkg and the rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dwpa_pkg::*;
  import dwpa_tb_pkg::*;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [StampW-1:0] cfg_wr_data;

  dwpa_in_if  in_ch ();
  dwpa_out_if out_ch ();

  dual_wheel_period_averager u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  period_scoreboard  sb = new();
  int                results_seen = 0;
  int                burst_left = 0;
  logic [StampW-1:0] last_stamp [2] = '{16'd0, 16'd0};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  // sender gap: mostly short, a few long, with runs of back-to-back transfers
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(10, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [StampW-1:0] next_stamp(logic wheel);
    int r;
    int t;
    int span;
    r    = $urandom_range(0, 99);
    span = (sb.top < 3000) ? sb.top : 3000;
    if (r < 45) begin
      t = (int'(last_stamp[wheel]) + $urandom_range(1, span)) % (int'(sb.top) + 1);
    end else if (r < 65) begin
      t = $urandom_range(0, 65535);
    end else if (r < 75) begin
      t = last_stamp[wheel];
    end else if (r < 85) begin
      t = int'(sb.top) - $urandom_range(0, (sb.top < 50) ? sb.top : 50);
    end else if (r < 92) begin
      t = $urandom_range(0, 1) ? 65535 : 0;
    end else begin
      t = $urandom_range(0, 50);
    end
    last_stamp[wheel] = StampW'(t);
    return StampW'(t);
  endfunction

  task automatic send_capture(input logic wheel, input logic [StampW-1:0] stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.wheel     <= wheel;
    in_ch.timestamp <= stamp;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_capture(wheel, stamp);
  endtask

  task automatic random_captures(input int count);
    logic w;
    for (int i = 0; i < count; i++) begin
      w = 1'($urandom_range(0, 1));
      send_capture(w, next_stamp(w));
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_top(input logic [StampW-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.set_top(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // output ready: random stalls, free-flowing stretches, two long hold-offs
  initial begin
    int mode;
    int hold_mark;
    hold_mark = 300;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (results_seen >= hold_mark && hold_mark < 2000) begin
        out_ch.ready <= 1'b0;
        repeat (250) @(negedge clk);
        hold_mark += 1000;
      end
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end else if (mode < 9) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.wheel_out, out_ch.period_done,
                      out_ch.new_period, out_ch.average_period);
      results_seen++;
    end
  end

  initial begin
    logic [StampW-1:0] s;
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.wheel     = 1'b0;
    in_ch.timestamp = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // reset counter top: ordinary, clamped, equal and wrapped pairs
    send_capture(1'b0, 16'd0);
    send_capture(1'b0, 16'hFFFF);
    send_capture(1'b1, 16'hFFFF);
    send_capture(1'b1, 16'd0);
    send_capture(1'b0, 16'd1234);
    send_capture(1'b0, 16'd1234);
    send_capture(1'b1, 16'd100);
    send_capture(1'b1, 16'd50);
    send_capture(1'b0, 16'd60000);
    send_capture(1'b0, 16'd0);
    send_capture(1'b1, 16'd60001);
    send_capture(1'b1, 16'd60001);
    send_capture(1'b0, 16'd5);
    send_capture(1'b1, 16'd7);
    send_capture(1'b0, 16'd9);
    send_capture(1'b1, 16'd3);
    random_captures(400);
    drain_results();

    // widest counter: largest period, then a store full of it
    write_top(16'hFFFF);
    send_capture(1'b0, 16'd0);
    send_capture(1'b0, 16'd0);
    send_capture(1'b1, 16'hFFFF);
    send_capture(1'b1, 16'hFFFF);
    for (int i = 0; i < DefStoreDepth; i++) begin
      for (int w = 0; w < 2; w++) begin
        s = StampW'($urandom_range(0, 65535));
        send_capture(1'(w), s);
        send_capture(1'(w), s);
      end
    end
    random_captures(500);
    drain_results();

    // smallest counter: a first stamp above the top, an equal pair at the top, then random traffic
    write_top(16'd1);
    send_capture(1'b0, 16'hFFFF);
    send_capture(1'b0, 16'd0);
    send_capture(1'b1, 16'd1);
    send_capture(1'b1, 16'd1);
    random_captures(300);
    drain_results();

    write_top(StampW'($urandom_range(2, 65534)));
    random_captures(500);
    drain_results();

    write_top(TopReset);
    random_captures(300);
    drain_results();

    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: dual_wheel_period_averager.f
rtl/core/dwpa_pkg.sv
rtl/core/dwpa_in_if.sv
rtl/core/dwpa_out_if.sv
rtl/core/dwpa_store.sv
rtl/core/dwpa_div.sv
rtl/core/dwpa_fifo.sv
rtl/core/dual_wheel_period_averager.sv
tb/dwpa_tb_pkg.sv
tb/tb_top.sv
